FILE: rtl/nrmc_pkg.sv
// Shared constants, character codes and helper functions for the RMC sentence parser.
package nrmc_pkg;

    localparam int CHAR_W = 8;
    localparam int TIME_W = 20;
    localparam int DEG_W  = 10;
    localparam int MW_W   = 7;
    localparam int FRAC_W = 20;
    localparam int CNT_W  = 3;
    localparam int SPD_W  = 14;
    localparam int COORD_W = 29;
    localparam int SPEED_W = 24;
    localparam int HOUR_W  = 7;
    localparam int OUT_DATA_W = 104;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_V     = 8'h56;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [2:0] PREFIX_LEN = 3'd7;

    // Result flag bits
    localparam int FL_TIME = 0;
    localparam int FL_FIX  = 1;
    localparam int FL_LAT  = 2;
    localparam int FL_LON  = 3;
    localparam int FL_FULL = 4;

    // Saturation limits
    localparam logic [23:0] TIME_MAX   = 24'd999999;
    localparam logic [13:0] DEG_MAX    = 14'd1023;
    localparam logic [16:0] SPD_MAX    = 17'd10000;
    localparam logic [30:0] MAG_MAX    = 31'd180000000;
    localparam logic [24:0] SPEED_MAX  = 25'd9999999;

    // Reciprocal constants for division by constants
    localparam logic [20:0] HOUR_RECIP  = 21'd1717987;   // 2^34 / 10000
    localparam int          HOUR_SHIFT  = 34;
    localparam logic [17:0] MIN_RECIP   = 18'd167773;    // 2^24 / 100
    localparam int          MIN_SHIFT   = 24;
    localparam logic [25:0] D15_RECIP   = 26'd35791395;  // 2^29 / 15
    localparam int          D15_SHIFT   = 29;
    localparam logic [14:0] D10S_RECIP  = 15'd26215;     // 2^18 / 10
    localparam int          D10S_SHIFT  = 18;
    localparam logic [6:0]  D10N_RECIP  = 7'd103;        // 2^10 / 10
    localparam int          D10N_SHIFT  = 10;

    // Expected prefix character at each position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;   // $
            3'd1:    ch = 8'h47;   // G
            3'd2:    ch = 8'h50;   // P
            3'd3:    ch = 8'h52;   // R
            3'd4:    ch = 8'h4D;   // M
            3'd5:    ch = 8'h43;   // C
            3'd6:    ch = 8'h2C;   // ,
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Power of ten, clamped at one million
    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] v;
        case (n)
            3'd0:    v = 20'd1;
            3'd1:    v = 20'd10;
            3'd2:    v = 20'd100;
            3'd3:    v = 20'd1000;
            3'd4:    v = 20'd10000;
            3'd5:    v = 20'd100000;
            default: v = 20'd1000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/nmea_rmc_sentence_parser_unit.sv
// RMC sentence parser: character stream in, one decoded fix record per buffer out.
//
// One character is taken per cycle on the slave stream; s_tlast marks the last
// character of a buffer, and that transaction yields one record on the master
// stream through a capture register, three arithmetic stages and the output
// register. Parsing state is updated in the accepting cycle, so a new buffer
// may start in the cycle right after tlast. Throughput is one character per
// cycle; s_tready drops only while the output register holds a record the
// sink has not taken. Coordinates, time and speed are scaled by constant
// multiplies (reciprocals for the divisions) spread over the pipeline stages.
module nmea_rmc_sentence_parser_unit #(
    parameter int MINUTE_FRAC_DIGITS = 4,
    parameter int SPEED_FRAC_DIGITS  = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,    // [7:0] char_code
    input  logic         s_tlast,    // end_of_buffer
    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] fully_parsed, [1] time_ok, [2] fix_ok, [9:3] hour, [16:10] minute,
    // [17] lat_ok, [46:18] latitude, [47] lon_ok, [76:48] longitude,
    // [100:77] speed, [103:101] zero
    output logic [103:0] m_tdata
);

    localparam logic [19:0] MIN_SCALE  = 20'(10 ** MINUTE_FRAC_DIGITS);
    localparam logic [19:0] Y_SCALE    = 20'(10 ** (6 - MINUTE_FRAC_DIGITS));
    localparam logic [2:0]  MIN_DIGITS = 3'(MINUTE_FRAC_DIGITS);
    localparam logic [2:0]  SPD_DIGITS = 3'(SPEED_FRAC_DIGITS);
    localparam bit          SPD_DIV    = (SPEED_FRAC_DIGITS > 3);
    localparam logic [9:0]  SPD_MULT   =
        10'(10 ** ((SPEED_FRAC_DIGITS > 3) ? 0 : (3 - SPEED_FRAC_DIGITS)));

    typedef enum logic [3:0] {
        PH_PREFIX, PH_TIME, PH_SKIP, PH_STATUS, PH_GAP,
        PH_LAT_INT, PH_LAT_FRAC, PH_LAT_HEMI, PH_LAT_END,
        PH_LON_INT, PH_LON_FRAC, PH_LON_HEMI, PH_LON_END,
        PH_SPD_INT, PH_SPD_FRAC, PH_DONE
    } phase_t;

    // Parser state
    phase_t       phase_reg, phase_next;
    logic [2:0]   pos_reg, pos_next;
    logic [19:0]  time_reg, time_next;
    logic [9:0]   deg_reg, deg_next;
    logic [6:0]   mw_reg, mw_next;
    logic [19:0]  frac_reg, frac_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic [4:0]   flags_reg, flags_next;
    logic [13:0]  spd_reg, spd_next;
    logic         failed_reg, failed_next;
    logic [9:0]   lat_deg_reg, lat_deg_next, lon_deg_reg, lon_deg_next;
    logic [6:0]   lat_mw_reg, lat_mw_next, lon_mw_reg, lon_mw_next;
    logic [19:0]  lat_frac_reg, lat_frac_next, lon_frac_reg, lon_frac_next;
    logic [2:0]   lat_cnt_reg, lat_cnt_next, lon_cnt_reg, lon_cnt_next;
    logic         lat_neg_reg, lat_neg_next, lon_neg_reg, lon_neg_next;

    logic         advance;
    logic         accept;
    logic         dig;
    logic [3:0]   dval;
    logic [7:0]   ch;
    logic [23:0]  time_mul;
    logic [13:0]  mw_q_full;
    logic [6:0]   mw_q;
    logic [13:0]  deg_mul;
    logic [6:0]   mw_rem;
    logic [16:0]  spd_mul;
    logic [4:0]   flags_final;

    assign advance = !m_tvalid || m_tready;
    assign s_tready = advance;
    assign accept = s_tvalid && advance;
    assign ch = s_tdata;
    assign dig = (ch >= nrmc_pkg::CH_ZERO) && (ch <= nrmc_pkg::CH_NINE);
    assign dval = dig ? 4'(ch - nrmc_pkg::CH_ZERO) : 4'd0;
    assign time_mul = 24'(time_reg) * 24'd10 + 24'(dval);
    assign mw_q_full = (14'(mw_reg) * 14'(nrmc_pkg::D10N_RECIP)) >> nrmc_pkg::D10N_SHIFT;
    assign mw_q = mw_q_full[6:0];
    assign deg_mul = 14'(deg_reg) * 14'd10 + 14'(mw_q);
    assign mw_rem = mw_reg - 7'(mw_q * 7'd10);
    assign spd_mul = 17'(spd_reg) * 17'd10 + 17'(dval);

    // Next parser state for the accepted character
    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        time_next = time_reg;
        deg_next = deg_reg;
        mw_next = mw_reg;
        frac_next = frac_reg;
        cnt_next = cnt_reg;
        flags_next = flags_reg;
        spd_next = spd_reg;
        failed_next = failed_reg;
        lat_deg_next = lat_deg_reg;
        lat_mw_next = lat_mw_reg;
        lat_frac_next = lat_frac_reg;
        lat_cnt_next = lat_cnt_reg;
        lat_neg_next = lat_neg_reg;
        lon_deg_next = lon_deg_reg;
        lon_mw_next = lon_mw_reg;
        lon_frac_next = lon_frac_reg;
        lon_cnt_next = lon_cnt_reg;
        lon_neg_next = lon_neg_reg;
        if (!failed_reg)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (pos_reg < nrmc_pkg::PREFIX_LEN && ch == nrmc_pkg::prefix_char(pos_reg))
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_next == nrmc_pkg::PREFIX_LEN)
                            phase_next = PH_TIME;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_TIME:
                begin
                    if (dig)
                        time_next = (time_mul > nrmc_pkg::TIME_MAX) ?
                                    nrmc_pkg::TIME_MAX[19:0] : time_mul[19:0];
                    else if (time_reg == 20'd0)
                        failed_next = 1'b1;
                    else
                    begin
                        flags_next[nrmc_pkg::FL_TIME] = 1'b1;
                        if (ch == nrmc_pkg::CH_COMMA)
                            phase_next = PH_STATUS;
                        else
                        begin
                            phase_next = PH_SKIP;
                            if (ch == nrmc_pkg::CH_NUL)
                                failed_next = 1'b1;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (ch == nrmc_pkg::CH_COMMA)
                        phase_next = PH_STATUS;
                    else if (ch == nrmc_pkg::CH_NUL)
                        failed_next = 1'b1;
                end
                PH_STATUS:
                begin
                    if (ch == nrmc_pkg::CH_A)
                    begin
                        flags_next[nrmc_pkg::FL_FIX] = 1'b1;
                        phase_next = PH_GAP;
                    end
                    else if (ch == nrmc_pkg::CH_V)
                        phase_next = PH_GAP;
                    else
                        failed_next = 1'b1;
                end
                PH_GAP:
                begin
                    if (ch == nrmc_pkg::CH_NUL)
                        failed_next = 1'b1;
                    else
                    begin
                        phase_next = PH_LAT_INT;
                        deg_next = '0;
                        mw_next = '0;
                        pos_next = '0;
                        frac_next = '0;
                        cnt_next = '0;
                    end
                end
                PH_LAT_INT, PH_LON_INT:
                begin
                    if (dig)
                    begin
                        deg_next = (deg_mul > nrmc_pkg::DEG_MAX) ?
                                   nrmc_pkg::DEG_MAX[9:0] : deg_mul[9:0];
                        mw_next = 7'(mw_rem * 7'd10) + 7'(dval);
                        if (pos_reg < 3'd2)
                            pos_next = pos_reg + 3'd1;
                    end
                    else if (ch == nrmc_pkg::CH_POINT && pos_reg >= 3'd2)
                        phase_next = (phase_reg == PH_LAT_INT) ? PH_LAT_FRAC : PH_LON_FRAC;
                    else
                        failed_next = 1'b1;
                end
                PH_LAT_FRAC, PH_LON_FRAC:
                begin
                    if (dig)
                    begin
                        if (cnt_reg < MIN_DIGITS)
                        begin
                            frac_next = 20'(frac_reg * 20'd10) + 20'(dval);
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    else if (ch == nrmc_pkg::CH_COMMA)
                        phase_next = (phase_reg == PH_LAT_FRAC) ? PH_LAT_HEMI : PH_LON_HEMI;
                    else
                        failed_next = 1'b1;
                end
                PH_LAT_HEMI:
                begin
                    if (ch == nrmc_pkg::CH_N || ch == nrmc_pkg::CH_S)
                    begin
                        lat_deg_next = deg_reg;
                        lat_mw_next = mw_reg;
                        lat_frac_next = frac_reg;
                        lat_cnt_next = cnt_reg;
                        lat_neg_next = (ch == nrmc_pkg::CH_S);
                        phase_next = PH_LAT_END;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_LON_HEMI:
                begin
                    if (ch == nrmc_pkg::CH_E || ch == nrmc_pkg::CH_W)
                    begin
                        lon_deg_next = deg_reg;
                        lon_mw_next = mw_reg;
                        lon_frac_next = frac_reg;
                        lon_cnt_next = cnt_reg;
                        lon_neg_next = (ch == nrmc_pkg::CH_W);
                        phase_next = PH_LON_END;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_LAT_END:
                begin
                    if (ch == nrmc_pkg::CH_COMMA)
                    begin
                        flags_next[nrmc_pkg::FL_LAT] = 1'b1;
                        phase_next = PH_LON_INT;
                        deg_next = '0;
                        mw_next = '0;
                        pos_next = '0;
                        frac_next = '0;
                        cnt_next = '0;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_LON_END:
                begin
                    if (ch == nrmc_pkg::CH_COMMA)
                    begin
                        flags_next[nrmc_pkg::FL_LON] = 1'b1;
                        flags_next[nrmc_pkg::FL_FULL] = 1'b1;
                        phase_next = PH_SPD_INT;
                        spd_next = '0;
                        frac_next = '0;
                        cnt_next = '0;
                    end
                    else
                        failed_next = 1'b1;
                end
                PH_SPD_INT:
                begin
                    if (dig)
                        spd_next = (spd_mul > nrmc_pkg::SPD_MAX) ?
                                   nrmc_pkg::SPD_MAX[13:0] : spd_mul[13:0];
                    else if (ch == nrmc_pkg::CH_POINT)
                        phase_next = PH_SPD_FRAC;
                    else
                        phase_next = PH_DONE;
                end
                PH_SPD_FRAC:
                begin
                    if (dig)
                    begin
                        if (cnt_reg < SPD_DIGITS)
                        begin
                            frac_next = 20'(frac_reg * 20'd10) + 20'(dval);
                            cnt_next = cnt_reg + 3'd1;
                        end
                    end
                    else
                        phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // Apply the end-of-string terminator: only the time field can still earn its flag
    always_comb
    begin
        flags_final = flags_next;
        if (!failed_next && phase_next == PH_TIME && time_next != 20'd0)
            flags_final[nrmc_pkg::FL_TIME] = 1'b1;
    end

    // Hold parser state; restart after the last character of a buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            pos_reg <= '0;
            time_reg <= '0;
            deg_reg <= '0;
            mw_reg <= '0;
            frac_reg <= '0;
            cnt_reg <= '0;
            flags_reg <= '0;
            spd_reg <= '0;
            failed_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                phase_reg <= PH_PREFIX;
                pos_reg <= '0;
                time_reg <= '0;
                deg_reg <= '0;
                mw_reg <= '0;
                frac_reg <= '0;
                cnt_reg <= '0;
                flags_reg <= '0;
                spd_reg <= '0;
                failed_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg <= pos_next;
                time_reg <= time_next;
                deg_reg <= deg_next;
                mw_reg <= mw_next;
                frac_reg <= frac_next;
                cnt_reg <= cnt_next;
                flags_reg <= flags_next;
                spd_reg <= spd_next;
                failed_reg <= failed_next;
            end
        end
    end

    // Hold finished coordinate components (read only once their flag is set)
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lat_deg_reg <= lat_deg_next;
            lat_mw_reg <= lat_mw_next;
            lat_frac_reg <= lat_frac_next;
            lat_cnt_reg <= lat_cnt_next;
            lat_neg_reg <= lat_neg_next;
            lon_deg_reg <= lon_deg_next;
            lon_mw_reg <= lon_mw_next;
            lon_frac_reg <= lon_frac_next;
            lon_cnt_reg <= lon_cnt_next;
            lon_neg_reg <= lon_neg_next;
        end
    end

    // Pipeline valid bits
    logic v0_reg, v1_reg, v2_reg, v3_reg, out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v0_reg <= accept && s_tlast;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // Stage 0: capture the finished buffer
    logic [4:0]  f0_reg, f1_reg, f2_reg, f3_reg;
    logic [19:0] t0_reg, t1_reg;
    logic [9:0]  ad0_reg, od0_reg;
    logic [6:0]  am0_reg, om0_reg;
    logic [19:0] af0_reg, of0_reg;
    logic [2:0]  ac0_reg, oc0_reg;
    logic        an0_reg, an1_reg, an2_reg, an3_reg;
    logic        on0_reg, on1_reg, on2_reg, on3_reg;
    logic [13:0] sp0_reg;
    logic [19:0] sf0_reg;
    logic [2:0]  sc0_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f0_reg <= flags_final;
            t0_reg <= time_next;
            ad0_reg <= lat_deg_next;
            am0_reg <= lat_mw_next;
            af0_reg <= lat_frac_next;
            ac0_reg <= lat_cnt_next;
            an0_reg <= lat_neg_next;
            od0_reg <= lon_deg_next;
            om0_reg <= lon_mw_next;
            of0_reg <= lon_frac_next;
            oc0_reg <= lon_cnt_next;
            on0_reg <= lon_neg_next;
            sp0_reg <= spd_next;
            sf0_reg <= frac_next;
            sc0_reg <= cnt_next;
        end
    end

    // Stage 1: hour, fraction scaling, degree scaling
    logic [6:0]  hour1_reg, hour2_reg, hour3_reg;
    logic [19:0] afs1_reg, ofs1_reg;
    logic [26:0] amp1_reg, omp1_reg;
    logic [29:0] adm1_reg, adm2_reg, adm3_reg, odm1_reg, odm2_reg, odm3_reg;
    logic [19:0] sfs1_reg;
    logic [23:0] spk1_reg, spk2_reg;
    logic [63:0] hour_prod, afs_prod, ofs_prod, sfs_prod;

    always_comb
    begin
        hour_prod = 64'(t0_reg) * 64'(nrmc_pkg::HOUR_RECIP);
        afs_prod = 64'(af0_reg) * 64'(nrmc_pkg::pow10(MIN_DIGITS - ac0_reg));
        ofs_prod = 64'(of0_reg) * 64'(nrmc_pkg::pow10(MIN_DIGITS - oc0_reg));
        sfs_prod = 64'(sf0_reg) * 64'(nrmc_pkg::pow10(SPD_DIGITS - sc0_reg));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_reg <= f0_reg;
            t1_reg <= t0_reg;
            hour1_reg <= 7'(hour_prod >> nrmc_pkg::HOUR_SHIFT);
            afs1_reg <= afs_prod[19:0];
            ofs1_reg <= ofs_prod[19:0];
            amp1_reg <= 27'(27'(am0_reg) * 27'(MIN_SCALE));
            omp1_reg <= 27'(27'(om0_reg) * 27'(MIN_SCALE));
            adm1_reg <= 30'(30'(ad0_reg) * 30'd1000000);
            odm1_reg <= 30'(30'(od0_reg) * 30'd1000000);
            an1_reg <= an0_reg;
            on1_reg <= on0_reg;
            sfs1_reg <= sfs_prod[19:0];
            spk1_reg <= 24'(24'(sp0_reg) * 24'd1000);
        end
    end

    // Stage 2: remainder of time, minutes scaled to millionths, speed fraction in thousandths
    logic [13:0] rem2_reg;
    logic [26:0] ay2_reg, oy2_reg;
    logic [13:0] ms2_reg;
    logic [63:0] ms_prod;

    always_comb
    begin
        if (SPD_DIV)
            ms_prod = (64'(sfs1_reg) * 64'(nrmc_pkg::D10S_RECIP)) >> nrmc_pkg::D10S_SHIFT;
        else
            ms_prod = 64'(sfs1_reg) * 64'(SPD_MULT);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f2_reg <= f1_reg;
            hour2_reg <= hour1_reg;
            rem2_reg <= 14'(t1_reg - 20'(hour1_reg * 20'd10000));
            ay2_reg <= 27'((amp1_reg + 27'(afs1_reg)) * 27'(Y_SCALE));
            oy2_reg <= 27'((omp1_reg + 27'(ofs1_reg)) * 27'(Y_SCALE));
            adm2_reg <= adm1_reg;
            odm2_reg <= odm1_reg;
            an2_reg <= an1_reg;
            on2_reg <= on1_reg;
            ms2_reg <= ms_prod[13:0];
            spk2_reg <= spk1_reg;
        end
    end

    // Stage 3: minute, minutes divided by sixty, speed total
    logic [6:0]  min3_reg;
    logic [20:0] aq3_reg, oq3_reg;
    logic [23:0] spd3_reg;
    logic [63:0] min_prod, aq_prod, oq_prod;
    logic [24:0] spd_sum;

    always_comb
    begin
        min_prod = (64'(rem2_reg) * 64'(nrmc_pkg::MIN_RECIP)) >> nrmc_pkg::MIN_SHIFT;
        aq_prod = (64'(ay2_reg[26:2]) * 64'(nrmc_pkg::D15_RECIP)) >> nrmc_pkg::D15_SHIFT;
        oq_prod = (64'(oy2_reg[26:2]) * 64'(nrmc_pkg::D15_RECIP)) >> nrmc_pkg::D15_SHIFT;
        spd_sum = 25'(spk2_reg) + 25'(ms2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f3_reg <= f2_reg;
            hour3_reg <= hour2_reg;
            min3_reg <= min_prod[6:0];
            aq3_reg <= aq_prod[20:0];
            oq3_reg <= oq_prod[20:0];
            adm3_reg <= adm2_reg;
            odm3_reg <= odm2_reg;
            an3_reg <= an2_reg;
            on3_reg <= on2_reg;
            spd3_reg <= (spd_sum > nrmc_pkg::SPEED_MAX) ?
                        nrmc_pkg::SPEED_MAX[23:0] : spd_sum[23:0];
        end
    end

    // Output stage: sum, saturate and sign the coordinates; mask unearned fields
    logic [30:0] amag, omag;
    logic [28:0] aval, oval;
    logic [103:0] out_next;
    logic [103:0] out_reg;

    always_comb
    begin
        amag = 31'(adm3_reg) + 31'(aq3_reg);
        omag = 31'(odm3_reg) + 31'(oq3_reg);
        if (amag > nrmc_pkg::MAG_MAX)
            amag = nrmc_pkg::MAG_MAX;
        if (omag > nrmc_pkg::MAG_MAX)
            omag = nrmc_pkg::MAG_MAX;
        aval = an3_reg ? 29'(-amag) : amag[28:0];
        oval = on3_reg ? 29'(-omag) : omag[28:0];
        out_next = '0;
        out_next[0] = f3_reg[nrmc_pkg::FL_FULL];
        out_next[1] = f3_reg[nrmc_pkg::FL_TIME];
        out_next[2] = f3_reg[nrmc_pkg::FL_FIX];
        out_next[9:3] = f3_reg[nrmc_pkg::FL_TIME] ? hour3_reg : 7'd0;
        out_next[16:10] = f3_reg[nrmc_pkg::FL_TIME] ? min3_reg : 7'd0;
        out_next[17] = f3_reg[nrmc_pkg::FL_LAT];
        out_next[46:18] = f3_reg[nrmc_pkg::FL_LAT] ? aval : 29'd0;
        out_next[47] = f3_reg[nrmc_pkg::FL_LON];
        out_next[76:48] = f3_reg[nrmc_pkg::FL_LON] ? oval : 29'd0;
        out_next[100:77] = f3_reg[nrmc_pkg::FL_FULL] ? spd3_reg : 24'd0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign m_tdata = out_reg;

    // Checks
    a_last_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> v0_reg)
        else $error("buffer end did not enter the result pipeline");

    a_full_implies_parts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[1] && m_tdata[17] && m_tdata[47]))
        else $error("fully parsed without all field flags");

    a_lat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[17]) |-> (m_tdata[46:18] == 29'd0))
        else $error("latitude not zero without its flag");

    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[100:77] <= nrmc_pkg::SPEED_MAX[23:0]))
        else $error("speed above saturation limit");

endmodule
